>>> rtl/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

    // Fixed field widths
    localparam int CH_W    = 8;
    localparam int ADDR_W  = 11;
    localparam int END_W   = 7;
    localparam int TAB_W   = 5;
    localparam int SUM_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IW  = 2;
    localparam int OUT_W   = 41;
    localparam int TDATA_W = 48;

    // Control characters
    localparam logic [CH_W-1:0] CH_BS    = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

    // Saturation value of a recorded line end
    localparam logic [END_W-1:0] END_MAX = 7'h7F;

    // Register reset values
    localparam logic [7:0]       ATTR_RST = 8'h07;
    localparam logic [TAB_W-1:0] TAB_RST  = 5'd5;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        REG_CELL_ATTRIBUTE = 2'd0,
        REG_TAB_ADVANCE    = 2'd1,
        REG_CURSOR_ENABLE  = 2'd2
    } cfg_index_t;

    // Configuration seen by the cursor core
    typedef struct packed {
        logic [7:0]       cell_attribute;
        logic [TAB_W-1:0] tab_advance;
        logic             cursor_enable;
    } cfg_t;

    // One result; cell_write lands in the lowest bit
    typedef struct packed {
        logic              scroll_up;
        logic [ADDR_W-1:0] cursor_pos;
        logic              cursor_update;
        logic [7:0]        cell_attr;
        logic [CH_W-1:0]   cell_char;
        logic [ADDR_W-1:0] cell_addr;
        logic              cell_write;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/tcc_cursor_core.sv
`default_nettype none

module tcc_cursor_core
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [CH_W-1:0] ch,
    input  wire cfg_t            cfg,
    output result_t              result
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [END_W-1:0] le_reg  [ROWS];
    logic [END_W-1:0] le_next [ROWS];
    logic [END_W-1:0] le_rec  [ROWS];

    logic [CW-1:0]    col_c, nc;
    logic [RW-1:0]    row_c, row_up;
    logic [RW:0]      nr;
    logic [SUM_W-1:0] sum;
    logic [END_W-1:0] le_rd;
    logic             rec_we;
    logic [END_W-1:0] rec_val;
    logic             scr;

    function automatic logic [ADDR_W-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
        lin = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    // Decode one character and work out the new cursor
    always_comb begin
        col_c   = ({1'b0, col_reg} >= (CW+1)'(COLUMNS)) ? CW'(COLUMNS - 1) : col_reg;
        row_c   = ({1'b0, row_reg} >= (RW+1)'(ROWS)) ? RW'(ROWS - 1) : row_reg;
        row_up  = row_c - RW'(1);
        le_rd   = le_reg[row_up];
        nc      = col_c;
        nr      = {1'b0, row_c};
        sum     = '0;
        rec_we  = 1'b0;
        rec_val = '0;
        scr     = 1'b0;
        result  = '0;

        case (ch)
            CH_LF, CH_CR: begin
                rec_we  = 1'b1;
                rec_val = END_W'(col_c);
                nc      = '0;
                nr      = {1'b0, row_c} + (RW+1)'(1);
            end
            CH_BS: begin
                if (col_c == '0) begin
                    rec_we = 1'b1;
                    if (row_c != '0) begin
                        nr = {1'b0, row_up};
                        nc = ({1'b0, le_rd} >= (END_W+1)'(COLUMNS)) ?
                             CW'(COLUMNS - 1) : le_rd[CW-1:0];
                        result.cell_write = 1'b1;
                    end
                end else begin
                    nc = col_c - CW'(1);
                    result.cell_write = 1'b1;
                end
                if (result.cell_write) begin
                    result.cell_addr = lin(nr[RW-1:0], nc);
                    result.cell_char = CH_SPACE;
                    result.cell_attr = cfg.cell_attribute;
                end
            end
            default: begin
                if (ch == CH_TAB) begin
                    sum = SUM_W'(col_c) + SUM_W'(cfg.tab_advance);
                end else begin
                    sum = SUM_W'(col_c) + SUM_W'(1);
                    result.cell_write = 1'b1;
                    result.cell_addr  = lin(row_c, col_c);
                    result.cell_char  = ch;
                    result.cell_attr  = cfg.cell_attribute;
                end
                if (sum >= SUM_W'(COLUMNS)) begin
                    rec_we  = 1'b1;
                    rec_val = (sum > SUM_W'(END_MAX)) ? END_MAX : sum[END_W-1:0];
                    nc      = '0;
                    nr      = {1'b0, row_c} + (RW+1)'(1);
                end else begin
                    nc = sum[CW-1:0];
                end
            end
        endcase

        // Falling off the bottom row scrolls the screen
        if (nr >= (RW+1)'(ROWS)) begin
            scr = 1'b1;
            nc  = '0;
            nr  = (RW+1)'(ROWS - 1);
        end

        col_next = nc;
        row_next = nr[RW-1:0];

        result.cursor_update = cfg.cursor_enable;
        result.cursor_pos    = lin(row_next, col_next);
        result.scroll_up     = scr;
    end

    // Record the line end, then shift the record up on a scroll
    always_comb begin
        for (int i = 0; i < ROWS; i++) begin
            le_rec[i] = (rec_we && (RW'(i) == row_c)) ? rec_val : le_reg[i];
        end
        for (int i = 0; i < ROWS; i++) begin
            if (scr && (i < ROWS - 1)) begin
                le_next[i] = le_rec[(i + 1) % ROWS];
            end else begin
                le_next[i] = le_rec[i];
            end
        end
    end

    // Hold cursor state; advance on every processed transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < ROWS; i++) begin
                le_reg[i] <= '0;
            end
        end else if (step) begin
            col_reg <= col_next;
            row_reg <= row_next;
            for (int i = 0; i < ROWS; i++) begin
                le_reg[i] <= le_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/text_console_cursor_engine_core.sv
// Channel   | Ports                          | Payload
// ----------+--------------------------------+------------------------------------
// input     | s_tvalid s_tready s_tdata[7:0] | ch
// result    | m_tvalid m_tready m_tdata[47:0]| one result per character
// config    | cfg_wr_en cfg_index cfg_wdata  | 0 attribute, 1 tab step, 2 cursor en
//
// One character per cycle while the output is not stalled; each result passes
// through the input register, then the cursor core into the result register.
// aresetn (synchronous, active low) empties both registers, puts the cursor at
// the top left, clears the line-end record and restores the register defaults.
// While m_tready is low the result is held and one more character is taken into
// the input register; s_tready then falls until the result leaves.

`default_nettype none

module text_console_cursor_engine_core
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // ch [7:0]
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,
    // cell_write [0], cell_addr [11:1], cell_char [19:12], cell_attr [27:20],
    // cursor_update [28], cursor_pos [39:29], scroll_up [40], zero [47:41]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_IW-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);

    logic            in_valid_reg;
    logic [CH_W-1:0] ch_reg;
    logic            out_valid_reg;
    result_t         out_reg;
    result_t         result;
    cfg_t            cfg_reg;
    logic            advance;
    logic            step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - OUT_W)'(0), out_reg};

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_attribute <= ATTR_RST;
            cfg_reg.tab_advance    <= TAB_RST;
            cfg_reg.cursor_enable  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CELL_ATTRIBUTE: cfg_reg.cell_attribute <= cfg_wdata;
                REG_TAB_ADVANCE:    cfg_reg.tab_advance    <= cfg_wdata[TAB_W-1:0];
                REG_CURSOR_ENABLE:  cfg_reg.cursor_enable  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
    end

    tcc_cursor_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .ch      (ch_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step) begin
            out_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tcc_checker.sv
`default_nettype none

module tcc_checker
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata
);

    localparam logic [ADDR_W-1:0] BOTTOM_POS = ADDR_W'((ROWS - 1) * COLUMNS);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Nothing comes out right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Without a cell write the cell fields are zero, and padding is always zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] || (m_tdata[27:1] == '0)) && (m_tdata[47:41] == '0))
        else $error("cell fields set without a cell write");

    // A scroll leaves the cursor at the start of the bottom row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40] |-> m_tdata[39:29] == BOTTOM_POS)
        else $error("cursor not on bottom row after scroll");

    // A ready sink never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

endmodule

bind text_console_cursor_engine_core tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top
    import tcc_pkg::*;
();

    localparam int COLS          = 80;
    localparam int ROWS_N        = 25;
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_PRINTS    = 40;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 115;

    typedef enum int {
        RUN_TEXT,
        RUN_NEWLINE,
        RUN_TAB,
        RUN_ERASE,
        RUN_NOISE
    } run_kind_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = REG_CELL_ATTRIBUTE;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // Cursor tracker: own copy of the cursor, line-end record and registers
    logic [6:0]            track_col = '0;
    logic [4:0]            track_row = '0;
    logic [END_W-1:0]      line_end_rec [ROWS_N];
    logic [7:0]            attr_reg  = ATTR_RST;
    logic [TAB_W-1:0]      tab_step  = TAB_RST;
    logic                  cursor_en = 1'b0;

    result_t               cell_updates_due [$];
    int                    mismatch_count = 0;
    int                    idle_cycles    = 0;
    int                    stall_left     = 0;
    bit                    tx_gaps        = 1'b0;
    bit                    rx_stalls      = 1'b0;

    text_console_cursor_engine_core #(
        .COLUMNS (COLS),
        .ROWS    (ROWS_N)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    function automatic logic [ADDR_W-1:0] grid_index(input int row, input int col);
        return ADDR_W'(row * COLS + col);
    endfunction

    // Saturate a recorded line end at the top of its field
    function automatic void note_line_end(input int row, input int col);
        if (row < ROWS_N)
            line_end_rec[row] = (col > int'(END_MAX)) ? END_MAX : END_W'(col);
    endfunction

    // Work out the cell write and new cursor for one character
    function automatic result_t advance_cursor(input logic [CH_W-1:0] ch);
        result_t res;
        int      col;
        int      row;
        res = '0;
        col = int'(track_col);
        row = int'(track_row);
        if (row >= ROWS_N)
            row = ROWS_N - 1;
        if (col >= COLS)
            col = COLS - 1;

        if (ch == CH_LF || ch == CH_CR) begin
            note_line_end(row, col);
            col = 0;
            row++;
        end else if (ch == CH_BS) begin
            if (col == 0) begin
                note_line_end(row, 0);
                if (row != 0) begin
                    row--;
                    col = int'(line_end_rec[row]);
                    if (col >= COLS)
                        col = COLS - 1;
                    res.cell_write = 1'b1;
                end
            end else begin
                col--;
                res.cell_write = 1'b1;
            end
            if (res.cell_write) begin
                res.cell_addr = grid_index(row, col);
                res.cell_char = CH_SPACE;
                res.cell_attr = attr_reg;
            end
        end else begin
            if (ch == CH_TAB) begin
                col += int'(tab_step);
            end else begin
                res.cell_write = 1'b1;
                res.cell_addr  = grid_index(row, col);
                res.cell_char  = ch;
                res.cell_attr  = attr_reg;
                col++;
            end
            if (col >= COLS) begin
                note_line_end(row, col);
                col = 0;
                row++;
            end
        end

        // Past the bottom row: shift the line-end record up, keep the last entry
        if (row >= ROWS_N) begin
            res.scroll_up = 1'b1;
            for (int i = 0; i < ROWS_N - 1; i++)
                line_end_rec[i] = line_end_rec[i + 1];
            col = 0;
            row = ROWS_N - 1;
        end

        track_col         = 7'(col);
        track_row         = 5'(row);
        res.cursor_update = cursor_en;
        res.cursor_pos    = grid_index(row, col);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        if (!tx_gaps)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one character, wait for its transfer, then maybe idle
    task automatic send_char(input logic [CH_W-1:0] ch);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        cell_updates_due.push_back(advance_cursor(ch));
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Drop valid and hold until every outstanding result has arrived
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (cell_updates_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CELL_ATTRIBUTE: attr_reg  = value[7:0];
            REG_TAB_ADVANCE:    tab_step  = value[TAB_W-1:0];
            REG_CURSOR_ENABLE:  cursor_en = value[0];
            default: ;
        endcase
    endtask

    // Result side: random stalls, mostly short
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_W-1:0];
            if (cell_updates_due.size() == 0) begin
                flag_mismatch("result with nothing due, cursor_pos",
                              int'(got.cursor_pos), 0);
            end else begin
                want = cell_updates_due.pop_front();
                if (got.cell_write != want.cell_write)
                    flag_mismatch("cell_write", int'(got.cell_write),
                                  int'(want.cell_write));
                if (got.cell_addr != want.cell_addr)
                    flag_mismatch("cell_addr", int'(got.cell_addr),
                                  int'(want.cell_addr));
                if (got.cell_char != want.cell_char)
                    flag_mismatch("cell_char", int'(got.cell_char),
                                  int'(want.cell_char));
                if (got.cell_attr != want.cell_attr)
                    flag_mismatch("cell_attr", int'(got.cell_attr),
                                  int'(want.cell_attr));
                if (got.cursor_update != want.cursor_update)
                    flag_mismatch("cursor_update", int'(got.cursor_update),
                                  int'(want.cursor_update));
                if (got.cursor_pos != want.cursor_pos)
                    flag_mismatch("cursor_pos", int'(got.cursor_pos),
                                  int'(want.cursor_pos));
                if (got.scroll_up != want.scroll_up)
                    flag_mismatch("scroll_up", int'(got.scroll_up),
                                  int'(want.scroll_up));
                if (m_tdata[TDATA_W-1:OUT_W] != '0)
                    flag_mismatch("tdata padding", int'(m_tdata[TDATA_W-1:OUT_W]), 0);
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL text_console_cursor_engine_core");
            $finish;
        end
    end

    // Defaults: erase at the top left, plain bytes, erase back over a row
    task automatic test_home_and_erase();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_char(CH_BS);
        send_char(8'h41);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7F);
        send_char(CH_BS);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_BS);
        send_char(CH_TAB);
        send_char(8'h5A);
    endtask

    // Wide tabs wrap the row; erase back clamps to the last column
    task automatic test_tab_wrap();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        write_reg(REG_CELL_ATTRIBUTE, 8'hFF);
        write_reg(REG_TAB_ADVANCE, 8'd16);
        write_reg(REG_CURSOR_ENABLE, 8'h01);
        repeat (5) send_char(CH_TAB);
        send_char(CH_BS);
        // zero step: the tab leaves the column alone
        write_reg(REG_TAB_ADVANCE, 8'hE0);
        send_char(CH_TAB);
        send_char(8'h71);
        write_reg(REG_TAB_ADVANCE, 8'hFF);
        repeat (3) send_char(CH_TAB);
    endtask

    // Run off the bottom row, then erase back into the shifted record
    task automatic test_scroll();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        write_reg(REG_CELL_ATTRIBUTE, 8'h00);
        write_reg(REG_TAB_ADVANCE, 8'd1);
        write_reg(REG_CURSOR_ENABLE, 8'hFE);
        send_char(8'h78);
        send_char(8'h79);
        repeat (26) send_char(CH_LF);
        send_char(CH_TAB);
        send_char(CH_BS);
        send_char(CH_BS);
        send_char(CH_BS);
    endtask

    // Phases of random text under changing registers and handshake pressure
    task automatic test_random_phases();
        logic [7:0]       attr_v;
        logic [TAB_W-1:0] tab_v;
        logic             cen_v;
        logic [CH_W-1:0]  ch;
        run_kind_t        kind;
        int               sent;
        int               run;
        int               pick;
        int               drain_at;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            attr_v    = 8'($urandom_range(0, 255));
            tab_v     = TAB_W'($urandom_range(1, 16));
            cen_v     = 1'($urandom_range(0, 1));
            tx_gaps   = 1'b1;
            rx_stalls = 1'b1;
            case (p)
                0: begin
                    attr_v = 8'h00;
                    tab_v  = TAB_W'(1);
                    cen_v  = 1'b1;
                end
                1: begin
                    attr_v    = 8'hFF;
                    tab_v     = TAB_W'(16);
                    cen_v     = 1'b0;
                    tx_gaps   = 1'b0;
                    rx_stalls = 1'b0;
                end
                3: begin
                    tab_v     = TAB_W'(0);
                    rx_stalls = 1'b0;
                end
                4: begin
                    tab_v   = TAB_W'(31);
                    tx_gaps = 1'b0;
                end
                default: ;
            endcase
            // Random upper bits on the narrow registers
            write_reg(REG_CELL_ATTRIBUTE, attr_v);
            write_reg(REG_TAB_ADVANCE, {3'($urandom_range(0, 7)), tab_v});
            write_reg(REG_CURSOR_ENABLE, {7'($urandom_range(0, 127)), cen_v});

            sent     = 0;
            drain_at = $urandom_range(20, PHASE_ITEMS - 20);
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    kind = RUN_TEXT;
                    run  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                       : $urandom_range(1, 12);
                end else if (pick < 55) begin
                    kind = RUN_NEWLINE;
                    run  = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(1, 2);
                end else if (pick < 65) begin
                    kind = RUN_TAB;
                    run  = $urandom_range(1, 4);
                end else if (pick < 82) begin
                    kind = RUN_ERASE;
                    run  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90)
                                                       : $urandom_range(1, 6);
                end else begin
                    kind = RUN_NOISE;
                    run  = $urandom_range(1, 3);
                end
                for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
                    case (kind)
                        RUN_TEXT:    ch = CH_W'($urandom_range(8'h20, 8'h7E));
                        RUN_NEWLINE: ch = ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR;
                        RUN_TAB:     ch = CH_TAB;
                        RUN_ERASE:   ch = CH_BS;
                        default:     ch = CH_W'($urandom_range(0, 255));
                    endcase
                    send_char(ch);
                    sent++;
                    // hold off once per phase until the pipeline is empty
                    if (sent == drain_at)
                        settle();
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < ROWS_N; i++)
            line_end_rec[i] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_home_and_erase();
        test_tab_wrap();
        test_scroll();
        test_random_phases();

        settle();
        repeat (6) @(posedge aclk);
        if (cell_updates_due.size() != 0)
            flag_mismatch("results never arrived", cell_updates_due.size(), 0);
        if (mismatch_count == 0) begin
            $display("PASS text_console_cursor_engine_core");
        end else begin
            $display("FAIL text_console_cursor_engine_core");
        end
        $finish;
    end

endmodule

`default_nettype wire
